### src/tcra_pkg.sv
// Shared constants, register indexes and sequencer states for the calibrated running average.
`timescale 1ns / 1ps

package tcra_pkg;

   // Default averaging window exponent (window = 2**AVG_SHIFT samples)
   localparam int AVG_SHIFT_DEF = 4;

   // Fixed field widths
   localparam int DATA_W    = 16;   // sample and calibration registers
   localparam int OUT_W     = 21;   // averaged temperature, signed
   localparam int CAL_SHIFT = 12;   // product scaling
   localparam int MUL_STEPS = DATA_W;
   localparam int CSR_IDX_W = 8;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_ZERO = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_COEF   = CSR_IDX_W'(1);

   // Configuration reset values
   localparam logic [DATA_W-1:0] OFFSET_ZERO_RST = DATA_W'(5740);
   localparam logic [DATA_W-1:0] GAIN_COEF_RST   = DATA_W'(1050);

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,   // waiting for a sample
      ST_MUL,    // bit-serial sample * gain
      ST_VAL,    // offset minus scaled product
      ST_ACC,    // accumulate and count
      ST_EMA,    // window full: shift average and leak accumulator
      ST_NEG,    // warm-up: take magnitude for the divider
      ST_DIV,    // restoring divide, one quotient bit per cycle
      ST_FIX,    // restore sign and clamp
      ST_OUT     // hand result to output register
   } state_type;

endpackage

### src/temp_calibrate_running_average_core.sv
// Top level: serial calibration, accumulation and averaging of temperature samples.
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_adc_sample[15:0]
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_avg_temp[20:0] (signed), rsp_warmed_up
//  csr     | in        | csr_valid/csr_ready  | csr_index[7:0], csr_wdata[15:0]
//
//  Each sample runs through the 16-step shift-add multiplier and, in warm-up, the
//  one-bit-per-cycle restoring divider over the accumulator width. A new sample is
//  taken only once the sequencer has returned to idle.
//  Reset is synchronous; it clears the accumulator, count, sequencer and output valid
//  and reloads the calibration registers. A stalled result sits in the output register
//  while the next sample is taken; only the final load waits for it to drain.
module temp_calibrate_running_average_core #(
   parameter int AVG_SHIFT = tcra_pkg::AVG_SHIFT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [tcra_pkg::DATA_W-1:0]           req_adc_sample,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [tcra_pkg::OUT_W-1:0]     rsp_avg_temp,
   output logic                                  rsp_warmed_up,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tcra_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tcra_pkg::DATA_W-1:0]           csr_wdata
);

   localparam int DATA_W = tcra_pkg::DATA_W;
   localparam int OUT_W  = tcra_pkg::OUT_W;
   localparam int ACC_W  = AVG_SHIFT + 22;
   localparam int CNT_W  = AVG_SHIFT + 1;
   localparam int STEP_W = $clog2(ACC_W);
   localparam int PSH_W  = 2 * DATA_W - tcra_pkg::CAL_SHIFT;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'((1 << AVG_SHIFT) - 1);
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

   // clamp a wide signed value to the output range
   function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [ACC_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > OUT_MAX) begin
         r = OUT_MAX[OUT_W-1:0];
      end else if (v < OUT_MIN) begin
         r = OUT_MIN[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   tcra_pkg::state_type state_ff, state_in;

   logic [DATA_W-1:0]       offset_ff, offset_in;
   logic [DATA_W-1:0]       gain_ff, gain_in;
   logic [DATA_W-1:0]       hi_ff, hi_in;       // product high half / partial sum
   logic [DATA_W-1:0]       lo_ff, lo_in;       // multiplier bits, then product low half
   logic [STEP_W-1:0]       step_ff, step_in;
   logic signed [OUT_W-1:0] val_ff, val_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    full_ff, full_in;
   logic                    neg_ff, neg_in;
   logic [ACC_W-1:0]        dq_ff, dq_in;       // dividend shifting out, quotient shifting in
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic signed [OUT_W-1:0] res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic                    rsp_warm_ff, rsp_warm_in;

   // combinational helpers
   logic [DATA_W:0]         mul_sum;
   logic [PSH_W-1:0]        prod_sh;
   logic signed [ACC_W:0]   acc_sum;
   logic signed [ACC_W-1:0] ema_avg;
   logic signed [ACC_W:0]   acc_diff;
   logic [CNT_W:0]          rem_sh;
   logic [CNT_W:0]          rem_sub;
   logic signed [ACC_W-1:0] quot;

   assign req_stall     = reset || (state_ff != tcra_pkg::ST_IDLE);
   assign csr_ready     = !reset;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_avg_temp  = rsp_avg_ff;
   assign rsp_warmed_up = rsp_warm_ff;

   // datapath terms used by the sequencer
   always_comb begin
      mul_sum  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, gain_ff} : {(DATA_W+1){1'b0}});
      prod_sh  = {hi_ff, lo_ff[DATA_W-1:tcra_pkg::CAL_SHIFT]};
      acc_sum  = {acc_ff[ACC_W-1], acc_ff} + {{(ACC_W+1-OUT_W){val_ff[OUT_W-1]}}, val_ff};
      ema_avg  = acc_ff >>> AVG_SHIFT;
      acc_diff = {acc_ff[ACC_W-1], acc_ff} - {ema_avg[ACC_W-1], ema_avg};
      rem_sh   = {rem_ff, dq_ff[ACC_W-1]};
      rem_sub  = rem_sh - {1'b0, cnt_ff};
      quot     = neg_ff ? -signed'(dq_ff) : signed'(dq_ff);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= tcra_pkg::OFFSET_ZERO_RST;
         gain_ff      <= tcra_pkg::GAIN_COEF_RST;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         gain_ff      <= gain_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      step_ff     <= step_in;
      val_ff      <= val_in;
      full_ff     <= full_in;
      neg_ff      <= neg_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_warm_ff <= rsp_warm_in;
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      offset_in    = offset_ff;
      gain_in      = gain_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      step_in      = step_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      full_in      = full_ff;
      neg_in       = neg_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_warm_in  = rsp_warm_ff;

      // result leaves on a completed transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes; unknown indexes are dropped
      if (csr_valid && csr_ready) begin
         if (csr_index == tcra_pkg::CSR_OFFSET_ZERO) begin
            offset_in = csr_wdata;
         end else if (csr_index == tcra_pkg::CSR_GAIN_COEF) begin
            gain_in = csr_wdata;
         end
      end

      unique case (state_ff)
         tcra_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               hi_in    = '0;
               lo_in    = req_adc_sample;
               step_in  = STEP_W'(tcra_pkg::MUL_STEPS - 1);
               state_in = tcra_pkg::ST_MUL;
            end
         end
         tcra_pkg::ST_MUL: begin
            // add gain when the low multiplier bit is set, then shift right
            hi_in   = mul_sum[DATA_W:1];
            lo_in   = {mul_sum[0], lo_ff[DATA_W-1:1]};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = tcra_pkg::ST_VAL;
            end
         end
         tcra_pkg::ST_VAL: begin
            val_in   = signed'(OUT_W'(offset_ff) - OUT_W'(prod_sh));
            state_in = tcra_pkg::ST_ACC;
         end
         tcra_pkg::ST_ACC: begin
            // saturating accumulate
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
               acc_in = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
               acc_in = acc_sum[ACC_W-1:0];
            end
            if (cnt_ff == CNT_FULL) begin
               full_in  = 1'b1;
               state_in = tcra_pkg::ST_EMA;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               full_in  = 1'b0;
               state_in = tcra_pkg::ST_NEG;
            end
         end
         tcra_pkg::ST_EMA: begin
            res_in = clamp_out(ema_avg);
            if (acc_diff[ACC_W] != acc_diff[ACC_W-1]) begin
               acc_in = acc_diff[ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
               acc_in = acc_diff[ACC_W-1:0];
            end
            state_in = tcra_pkg::ST_OUT;
         end
         tcra_pkg::ST_NEG: begin
            neg_in   = acc_ff[ACC_W-1];
            dq_in    = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
            rem_in   = '0;
            step_in  = STEP_W'(ACC_W - 1);
            state_in = tcra_pkg::ST_DIV;
         end
         tcra_pkg::ST_DIV: begin
            // one restoring step per cycle; divisor is the sample count
            if (!rem_sub[CNT_W]) begin
               rem_in = rem_sub[CNT_W-1:0];
               dq_in  = {dq_ff[ACC_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[CNT_W-1:0];
               dq_in  = {dq_ff[ACC_W-2:0], 1'b0};
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = tcra_pkg::ST_FIX;
            end
         end
         tcra_pkg::ST_FIX: begin
            res_in   = clamp_out(quot);
            state_in = tcra_pkg::ST_OUT;
         end
         tcra_pkg::ST_OUT: begin
            // load output once the previous result is gone or leaving
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = res_ff;
               rsp_warm_in  = full_ff;
               state_in     = tcra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcra_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### src/tcra_checker.sv
// Port-level checks for the calibrated running average core, bound to the top level.
`timescale 1ns / 1ps

module tcra_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [tcra_pkg::DATA_W-1:0]        req_adc_sample,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [tcra_pkg::OUT_W-1:0]  rsp_avg_temp,
   input logic                               rsp_warmed_up
);

   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   // a stalled sample holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_adc_sample))
      else $error("stalled sample changed");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_avg_temp) && $stable(rsp_warmed_up))
      else $error("stalled result changed");

   // the core is busy right after taking a sample
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("sample taken while previous one in flight");

   // no result can be produced in the cycle right after a sample transfer
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // reset leaves no pending result
   a_reset_clears: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind temp_calibrate_running_average_core tcra_checker u_tcra_checker (.*);

### dv/tb_temp_calibrate_running_average_core.sv
// Self-checking testbench for the calibrated running-average temperature core.
`timescale 1ns / 1ps

module tb_temp_calibrate_running_average_core;

   localparam int     DATA_W      = tcra_pkg::DATA_W;
   localparam int     OUT_W       = tcra_pkg::OUT_W;
   localparam int     CSR_IDX_W   = tcra_pkg::CSR_IDX_W;
   localparam int     CAL_SHIFT   = tcra_pkg::CAL_SHIFT;
   localparam int     AVG_SHIFT   = tcra_pkg::AVG_SHIFT_DEF;
   localparam longint WINDOW      = longint'(1) << AVG_SHIFT;
   localparam int     ACC_W       = AVG_SHIFT + 22;
   localparam longint ACC_MAX     = (longint'(1) << (ACC_W - 1)) - 1;
   localparam longint ACC_MIN     = -ACC_MAX - 1;
   localparam longint AVG_MAX     = (longint'(1) << (OUT_W - 1)) - 1;
   localparam longint AVG_MIN     = -AVG_MAX - 1;
   localparam int     NUM_SAMPLES = 1500;
   localparam int     HOLD_AT     = 120;    // result count that triggers the long back-pressure
   localparam int     HOLD_CYCLES = 400;
   localparam int     IDLE_LIMIT  = 5000;   // cycles without any transfer
   localparam int     SETTLE      = 60;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_IDX = tcra_pkg::CSR_GAIN_COEF;
   localparam logic [DATA_W-1:0]    ALL_ONES     = '1;

   typedef struct packed {
      logic signed [OUT_W-1:0] avg_temp;
      logic                    warmed_up;
   } avg_result_type;

   // DUT ports, known values from time zero
   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic [DATA_W-1:0]          req_adc_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic signed [OUT_W-1:0]    rsp_avg_temp;
   logic                       rsp_warmed_up;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index      = '0;
   logic [DATA_W-1:0]          csr_wdata      = '0;

   // predictor state and calibration copy
   logic [DATA_W-1:0] cal_offset = tcra_pkg::OFFSET_ZERO_RST;
   logic [DATA_W-1:0] cal_gain   = tcra_pkg::GAIN_COEF_RST;
   longint            acc_state  = 0;
   longint            count_state = 0;

   logic [DATA_W-1:0] sample_q[$];
   avg_result_type    expected_avg_q[$];

   int   error_count  = 0;
   int   results_seen = 0;
   int   send_gap     = 0;
   int   stall_left   = 0;
   int   stall_pick;
   int   idle_cycles  = 0;
   bit   hold_done    = 1'b0;
   bit   calm         = 1'b0;  // no idling on either side during this phase

   temp_calibrate_running_average_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_adc_sample (req_adc_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_avg_temp   (rsp_avg_temp),
      .rsp_warmed_up  (rsp_warmed_up),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint clamp_acc(longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
   endfunction

   // Calibrate one sample, fold it into the average and return the expected result
   function automatic avg_result_type calibrate_and_average(logic [DATA_W-1:0] s);
      longint         prod;
      longint         temp;
      longint         avg;
      avg_result_type r;
      prod      = longint'(s) * longint'(cal_gain);
      temp      = longint'(cal_offset) - (prod >> CAL_SHIFT);
      acc_state = clamp_acc(acc_state + temp);
      count_state++;
      if (count_state >= WINDOW) begin
         avg         = acc_state >>> AVG_SHIFT;   // floor
         acc_state   = clamp_acc(acc_state - avg);
         count_state = WINDOW - 1;
         r.warmed_up = 1'b1;
      end else begin
         avg         = acc_state / count_state;   // truncates toward zero
         r.warmed_up = 1'b0;
      end
      if (avg > AVG_MAX) avg = AVG_MAX;
      if (avg < AVG_MIN) avg = AVG_MIN;
      r.avg_temp = avg[OUT_W-1:0];
      return r;
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 19);
      if (roll == 0) return $urandom_range(20, 80);
      if (roll <= 5) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic [DATA_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ALL_ONES;
         2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
         3: return ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // Sample driver: predicts each transfer and launches the next queued sample
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_avg_q.push_back(calibrate_and_average(req_adc_sample));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               req_adc_sample <= sample_q.pop_front();
               req_valid      <= 1'b1;
               send_gap       <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_avg_q.size() == 0) begin
               $error("unexpected result: avg_temp %0d warmed_up %0b",
                      rsp_avg_temp, rsp_warmed_up);
               error_count++;
            end else begin
               avg_result_type exp_r;
               exp_r = expected_avg_q.pop_front();
               if (rsp_avg_temp !== exp_r.avg_temp) begin
                  $error("avg_temp: expected %0d, actual %0d",
                         exp_r.avg_temp, rsp_avg_temp);
                  error_count++;
               end
               if (rsp_warmed_up !== exp_r.warmed_up) begin
                  $error("warmed_up: expected %0b, actual %0b",
                         exp_r.warmed_up, rsp_warmed_up);
                  error_count++;
               end
            end
         end
         if (!hold_done && results_seen >= HOLD_AT) begin
            // long hold-off so the core fills up and stalls its input
            hold_done  <= 1'b1;
            rsp_stall  <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
         end else if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            stall_pick = pick_gap();
            rsp_stall  <= (stall_pick > 0);
            stall_left <= (stall_pick > 0) ? stall_pick - 1 : 0;
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One register write; calibration copy follows on the transfer
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == tcra_pkg::CSR_OFFSET_ZERO)
         cal_offset = data;
      else if (idx == tcra_pkg::CSR_GAIN_COEF)
         cal_gain = data;
   endtask

   task automatic write_cal(logic [DATA_W-1:0] offset, logic [DATA_W-1:0] gain);
      write_csr(tcra_pkg::CSR_OFFSET_ZERO, offset);
      write_csr(tcra_pkg::CSR_GAIN_COEF, gain);
   endtask

   // Wait until every queued sample has gone through and every result is back;
   // checked between edges so the driver's updates have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_valid || expected_avg_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_samples(logic [DATA_W-1:0] list[]);
      foreach (list[i]) sample_q.push_back(list[i]);
      wait_drained();
   endtask

   initial begin
      int phase_len;
      int samples_sent;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: warm-up with reset calibration, negative values early
      queue_samples('{16'h0000, ALL_ONES, 16'h0001, 16'h8000});
      // most negative calibrated value
      write_cal('0, ALL_ONES);
      queue_samples('{ALL_ONES, 16'h0000, 16'h7FFF});
      // largest calibrated value
      write_cal(ALL_ONES, '0);
      queue_samples('{ALL_ONES, 16'h0000, 16'hAAAA});
      // writes to unused indexes are ignored
      write_csr(CSR_LAST_IDX + CSR_IDX_W'(1), 16'h1234);
      write_csr('1, 16'h0000);
      queue_samples('{16'h5555});
      write_cal(ALL_ONES, ALL_ONES);
      queue_samples('{16'h0001, ALL_ONES, 16'h1000});
      // back to reset values, crossing the end of warm-up
      write_cal(tcra_pkg::OFFSET_ZERO_RST, tcra_pkg::GAIN_COEF_RST);
      queue_samples('{16'h0000, ALL_ONES, 16'h1234, ALL_ONES});
      // full window with negative accumulator: floor on the shift
      write_cal('0, ALL_ONES);
      queue_samples('{ALL_ONES, ALL_ONES, ALL_ONES});

      // random phases, each with its own calibration
      samples_sent = 0;
      while (samples_sent < NUM_SAMPLES) begin
         case ($urandom_range(0, 5))
            0: write_cal(tcra_pkg::OFFSET_ZERO_RST, tcra_pkg::GAIN_COEF_RST);
            1: write_cal('0, ALL_ONES);
            2: write_cal(ALL_ONES, '0);
            3: write_cal(ALL_ONES, ALL_ONES);
            4: write_csr(tcra_pkg::CSR_GAIN_COEF, DATA_W'($urandom));
            default: write_cal(DATA_W'($urandom), DATA_W'($urandom));
         endcase
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_IDX_W'($urandom_range(CSR_LAST_IDX + 1, (1 << CSR_IDX_W) - 1)),
                      DATA_W'($urandom));
         // first phase is long so the back-pressure hold hits a busy sender
         phase_len = (samples_sent == 0) ? 300 : $urandom_range(40, 160);
         calm      = (samples_sent != 0) && ($urandom_range(0, 3) == 0);
         repeat (phase_len) sample_q.push_back(pick_sample());
         samples_sent += phase_len;
         wait_drained();
      end

      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && expected_avg_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### files.f
src/tcra_pkg.sv
src/temp_calibrate_running_average_core.sv
src/tcra_checker.sv
dv/tb_temp_calibrate_running_average_core.sv
